### rtl/tqa_pkg.sv
// ----------------------------------------------------------------------------
// tqa_pkg
// Shared widths, constants and types of the tower quality average block.
// ----------------------------------------------------------------------------
package tqa_pkg;

  localparam int MAX_CRYSTALS = 32;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int THR_W  = 31;
  localparam int CNT_W  = $clog2(MAX_CRYSTALS + 1);
  localparam int SUM_W  = DATA_W + $clog2(MAX_CRYSTALS);
  localparam int PROD_W = THR_W + CNT_W;
  localparam int CMP_W  = ((SUM_W > PROD_W) ? SUM_W : PROD_W) + 1;
  localparam int STEP_W = $clog2(SUM_W + 1);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic signed [DATA_W-1:0] FX_TWO   = DATA_W'(2 << FRAC_W);
  localparam logic signed [DATA_W-1:0] FX_THREE = DATA_W'(3 << FRAC_W);
  localparam logic signed [DATA_W-1:0] FX_FIVE  = DATA_W'(5 << FRAC_W);

  // quality codes
  localparam logic [2:0] CODE_LOW        = 3'd0;
  localparam logic [2:0] CODE_HIGH       = 3'd1;
  localparam logic [2:0] CODE_EMPTY      = 3'd2;
  localparam logic [2:0] CODE_MASK_LOW   = 3'd3;
  localparam logic [2:0] CODE_MASK_HIGH  = 3'd4;
  localparam logic [2:0] CODE_MASK_EMPTY = 3'd5;

  // one finished tower, as handed from front to back
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        count;
    logic                    masked;
    logic [THR_W-1:0]        threshold;
  } tower_rec_t;

endpackage

### rtl/tqa_front.sv
// ----------------------------------------------------------------------------
// tqa_front
// Classifies each crystal word and accumulates the running tower totals.
// ----------------------------------------------------------------------------
module tqa_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 take,
  input  logic signed [tqa_pkg::DATA_W-1:0]    crystal_value,
  input  logic                                 last,
  input  logic                                 threshold_we,
  input  logic [tqa_pkg::THR_W-1:0]            threshold_wdata,
  output logic                                 rec_push,
  output tqa_pkg::tower_rec_t                  rec
);
  import tqa_pkg::*;

  logic [THR_W-1:0]        threshold;
  logic signed [SUM_W-1:0] running_sum;
  logic signed [SUM_W-1:0] running_sum_next;
  logic [CNT_W-1:0]        valid_count;
  logic [CNT_W-1:0]        valid_count_next;
  logic                    masked_flag;
  logic                    masked_flag_next;
  logic [CNT_W-1:0]        seen_count;
  logic [CNT_W-1:0]        seen_count_next;
  logic signed [SUM_W-1:0] v_ext;

  assign v_ext = SUM_W'(crystal_value);

  always_comb begin
    running_sum_next = running_sum;
    valid_count_next = valid_count;
    masked_flag_next = masked_flag;
    seen_count_next  = seen_count;
    if (take && (seen_count < CNT_W'(MAX_CRYSTALS))) begin
      seen_count_next = seen_count + 1'b1;
      if (threshold == '0) begin
        running_sum_next = running_sum + v_ext;
        valid_count_next = valid_count + 1'b1;
      end else if ((crystal_value < 0) || (crystal_value == FX_TWO)) begin
        // skipped
      end else if (crystal_value == FX_FIVE) begin
        masked_flag_next = 1'b1;
      end else if (crystal_value > FX_TWO) begin
        masked_flag_next = 1'b1;
        valid_count_next = valid_count + 1'b1;
        running_sum_next = running_sum + v_ext - SUM_W'(FX_THREE);
      end else begin
        valid_count_next = valid_count + 1'b1;
        running_sum_next = running_sum + v_ext;
      end
    end
  end

  assign rec_push      = take && last;
  assign rec.sum       = running_sum_next;
  assign rec.count     = valid_count_next;
  assign rec.masked    = masked_flag_next;
  assign rec.threshold = threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (threshold_we) begin
      threshold <= threshold_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      valid_count <= '0;
      masked_flag <= 1'b0;
      seen_count  <= '0;
    end else if (take) begin
      if (last) begin
        running_sum <= '0;
        valid_count <= '0;
        masked_flag <= 1'b0;
        seen_count  <= '0;
      end else begin
        running_sum <= running_sum_next;
        valid_count <= valid_count_next;
        masked_flag <= masked_flag_next;
        seen_count  <= seen_count_next;
      end
    end
  end

endmodule

### rtl/tqa_queue.sv
// ----------------------------------------------------------------------------
// tqa_queue
// Short queue of finished tower records between front and back.
// ----------------------------------------------------------------------------
module tqa_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tqa_pkg::tower_rec_t wdata,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output tqa_pkg::tower_rec_t rdata
);
  import tqa_pkg::*;

  tower_rec_t        slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign full    = (fill == QCNT_W'(QDEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### rtl/tqa_back.sv
// ----------------------------------------------------------------------------
// tqa_back
// Turns one tower record into the tower word: serial mean divider or
// threshold compare, then holds the word until it is popped.
// ----------------------------------------------------------------------------
module tqa_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              rec_valid,
  input  tqa_pkg::tower_rec_t               rec,
  output logic                              rec_pop,
  input  logic                              pop,
  output logic                              empty,
  output logic signed [tqa_pkg::DATA_W-1:0] tower_value
);
  import tqa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_FIN  = 5'b00100,
    S_CMP  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t                  state;
  logic signed [SUM_W-1:0] sum;
  logic [CNT_W-1:0]        divisor;
  logic                    masked;
  logic                    neg;
  logic [SUM_W-1:0]        dvd;
  logic [CNT_W-1:0]        rem;
  logic [STEP_W-1:0]       step;
  logic [PROD_W-1:0]       prod;
  logic [CNT_W:0]          trial;
  logic                    qbit;
  logic [DATA_W-1:0]       quot;
  logic                    below;
  logic [2:0]              code;

  assign rec_pop = (state == S_IDLE) && rec_valid;
  assign empty   = (state != S_OUT);

  assign trial = {rem, dvd[SUM_W-1]};
  assign qbit  = (trial >= {1'b0, divisor});
  assign quot  = dvd[DATA_W-1:0];
  assign below = $signed(CMP_W'(sum)) < $signed(CMP_W'(prod));

  always_comb begin
    if (masked) begin
      code = below ? CODE_MASK_LOW : CODE_MASK_HIGH;
    end else begin
      code = below ? CODE_LOW : CODE_HIGH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (rec_valid) begin
            sum     <= rec.sum;
            divisor <= rec.count;
            masked  <= rec.masked;
            neg     <= rec.sum[SUM_W-1];
            dvd     <= rec.sum[SUM_W-1] ? SUM_W'(-rec.sum) : SUM_W'(rec.sum);
            rem     <= '0;
            step    <= '0;
            prod    <= PROD_W'(rec.threshold) * PROD_W'(rec.count);
            if (rec.count == '0) begin
              if (rec.threshold == '0) begin
                tower_value <= '0;
              end else if (rec.masked) begin
                tower_value <= DATA_W'(CODE_MASK_EMPTY) << FRAC_W;
              end else begin
                tower_value <= DATA_W'(CODE_EMPTY) << FRAC_W;
              end
              state <= S_OUT;
            end else if (rec.threshold == '0) begin
              state <= S_DIV;
            end else begin
              state <= S_CMP;
            end
          end
        end
        S_DIV: begin
          rem  <= qbit ? CNT_W'(trial - {1'b0, divisor}) : CNT_W'(trial);
          dvd  <= {dvd[SUM_W-2:0], qbit};
          step <= step + 1'b1;
          if (step == STEP_W'(SUM_W - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          tower_value <= neg ? -quot : quot;
          state       <= S_OUT;
        end
        S_CMP: begin
          tower_value <= DATA_W'(code) << FRAC_W;
          state       <= S_OUT;
        end
        S_OUT: begin
          if (pop) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/tower_quality_average.sv
// ----------------------------------------------------------------------------
// tower_quality_average
// Reduces a stream of Q16.16 crystal words to one word per tower.
// ----------------------------------------------------------------------------
// Crystal words are taken one per clock while full is low; full rises only
// when two finished towers are already waiting in the queue behind the
// accumulator. Each tower is finished in the back end: a quality code is
// set in a compare state, a plain mean is divided one quotient bit per cycle
// over the 37-bit sum, then sign-fixed; an empty tower skips both. The tower
// word then sits on tower_value until popped. Writing threshold as zero
// selects plain averaging; any other value selects quality codes.
module tower_quality_average (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic signed [tqa_pkg::DATA_W-1:0] crystal_value,
  input  logic                              last,
  input  logic                              threshold_we,
  input  logic [tqa_pkg::THR_W-1:0]         threshold,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [tqa_pkg::DATA_W-1:0] tower_value
);
  import tqa_pkg::*;

  tower_rec_t in_rec;
  tower_rec_t out_rec;
  logic       take;
  logic       rec_push;
  logic       rec_pop;
  logic       q_empty;

  assign take = push && !full;

  tqa_front u_front (
    .clk             (clk),
    .rst             (rst),
    .take            (take),
    .crystal_value   (crystal_value),
    .last            (last),
    .threshold_we    (threshold_we),
    .threshold_wdata (threshold),
    .rec_push        (rec_push),
    .rec             (in_rec)
  );

  tqa_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (rec_push),
    .wdata (in_rec),
    .pop   (rec_pop),
    .full  (full),
    .empty (q_empty),
    .rdata (out_rec)
  );

  tqa_back u_back (
    .clk         (clk),
    .rst         (rst),
    .rec_valid   (!q_empty),
    .rec         (out_rec),
    .rec_pop     (rec_pop),
    .pop         (pop),
    .empty       (empty),
    .tower_value (tower_value)
  );

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for tower_quality_average. Crystal words go in through
// the push/full queue port with random bursts and gaps. A behavioral model of
// the tower sum, count and mask state predicts each tower word. Every popped
// tower word is checked against the oldest prediction. Directed towers cover
// both modes, all quality codes, the crystal limit and a threshold change in
// the middle of a tower. One long receiver hold-off backs the block up into
// full; random phases then run under several thresholds.
// ----------------------------------------------------------------------------
module testbench;

  import tqa_pkg::*;

  localparam int SETTLE_CYCLES = 64;
  localparam logic signed [DATA_W-1:0] FX_ONE  = 32'sh0001_0000;
  localparam logic signed [DATA_W-1:0] FX_HALF = 32'sh0000_8000;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     push = 1'b0;
  logic                     full;
  logic signed [DATA_W-1:0] crystal_value = '0;
  logic                     last = 1'b0;
  logic                     threshold_we = 1'b0;
  logic [THR_W-1:0]         threshold = '0;
  logic                     empty;
  logic                     pop = 1'b0;
  logic signed [DATA_W-1:0] tower_value;

  // predictor state
  logic signed [DATA_W-1:0] tower_words_due[$];
  logic signed [DATA_W-1:0] due_word;
  logic [THR_W-1:0]         thr_now = '0;
  longint                   tower_sum = 0;
  int                       tower_count = 0;
  bit                       tower_masked = 1'b0;
  int                       tower_seen = 0;

  int errors = 0;
  int burst_left = 0;
  int hold_left = 0;
  int pop_mode = 0;
  int mode_left = 0;

  tower_quality_average u_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .crystal_value(crystal_value),
    .last         (last),
    .threshold_we (threshold_we),
    .threshold    (threshold),
    .empty        (empty),
    .pop          (pop),
    .tower_value  (tower_value)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

  task automatic absorb_crystal(input logic signed [DATA_W-1:0] value, input logic is_last);
    longint     v;
    longint     word;
    logic [2:0] code;
    v = longint'(value);
    if (tower_seen < MAX_CRYSTALS) begin
      tower_seen++;
      if (thr_now == 0) begin
        tower_sum += v;
        tower_count++;
      end else if (!(v < 0 || v == FX_TWO)) begin
        if (v == FX_FIVE) begin
          tower_masked = 1'b1;
        end else begin
          tower_count++;
          if (v > FX_TWO) begin
            tower_masked = 1'b1;
            tower_sum += v - FX_THREE;
          end else begin
            tower_sum += v;
          end
        end
      end
    end
    if (is_last) begin
      if (thr_now == 0) begin
        word = (tower_count == 0) ? 0 : tower_sum / longint'(tower_count);
      end else begin
        if (tower_count == 0)
          code = tower_masked ? CODE_MASK_EMPTY : CODE_EMPTY;
        else if (tower_sum < longint'(thr_now) * longint'(tower_count))
          code = tower_masked ? CODE_MASK_LOW : CODE_LOW;
        else
          code = tower_masked ? CODE_MASK_HIGH : CODE_HIGH;
        word = longint'(code) << FRAC_W;
      end
      tower_words_due.push_back(word[DATA_W-1:0]);
      tower_sum = 0;
      tower_count = 0;
      tower_masked = 1'b0;
      tower_seen = 0;
    end
  endtask

  task automatic send_crystal(input logic signed [DATA_W-1:0] value, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 :
            $urandom_range(1, ($urandom_range(0, 7) == 0) ? 20 : 5);
      if (gap > 0) begin
        @(negedge clk);
        push <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    push <= 1'b1;
    crystal_value <= value;
    last <= is_last;
    do @(posedge clk); while (full);
    absorb_crystal(value, is_last);
  endtask

  // wait until every tower word is out and the back end has gone quiet
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (tower_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    settle();
    @(negedge clk);
    threshold_we <= 1'b1;
    threshold <= value;
    @(posedge clk);
    thr_now = value;
    @(negedge clk);
    threshold_we <= 1'b0;
  endtask

  // receiver: changing stall pattern, plus a hold-off on request
  always @(negedge clk) begin
    if (mode_left == 0) begin
      pop_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(32, 256);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      case (pop_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= ($urandom_range(0, 3) == 0);
        default: pop <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (tower_words_due.size() == 0) begin
        $error("tower_value: no word expected, actual %0d", tower_value);
        errors++;
      end else begin
        due_word = tower_words_due.pop_front();
        if (tower_value !== due_word) begin
          $error("tower_value: expected %0d, actual %0d", due_word, tower_value);
          errors++;
        end
      end
    end
  end

  // reset threshold is zero: plain mean, extremes and truncation toward zero
  task automatic test_plain_extremes();
    send_crystal(32'sh7FFF_FFFF, 1'b1);
    send_crystal(32'sh8000_0000, 1'b1);
    send_crystal(32'sh8000_0000, 1'b0);
    send_crystal(32'sh7FFF_FFFF, 1'b0);
    send_crystal(-32'sd3, 1'b1);
  endtask

  task automatic test_quality_codes();
    write_threshold(THR_W'(FX_ONE));
    send_crystal(-32'sd1, 1'b1);
    send_crystal(FX_TWO, 1'b0);
    send_crystal(FX_FIVE, 1'b1);
    send_crystal(FX_HALF, 1'b1);
    send_crystal(FX_ONE, 1'b1);
    send_crystal(FX_THREE, 1'b0);
    send_crystal(FX_HALF, 1'b1);
    send_crystal(32'sh0004_0000, 1'b0);
    send_crystal(32'sh0001_8000, 1'b1);
    send_crystal(32'sh8000_0000, 1'b0);
    send_crystal(32'sh7FFF_FFFF, 1'b1);
    write_threshold(31'h7FFF_FFFF);
    send_crystal(32'sh0001_FFFF, 1'b1);
    write_threshold(31'd1);
    send_crystal(32'sd0, 1'b1);
    send_crystal(32'sd1, 1'b1);
  endtask

  task automatic test_threshold_change_mid_tower();
    write_threshold('0);
    send_crystal(32'sh000A_0000, 1'b0);
    send_crystal(32'sh0014_0000, 1'b0);
    write_threshold(THR_W'(FX_ONE));
    send_crystal(FX_FIVE, 1'b1);
    send_crystal(FX_HALF, 1'b0);
    write_threshold('0);
    send_crystal(32'shFFF9_0000, 1'b1);
  endtask

  // words past the crystal limit must not reach the mean
  task automatic test_crystal_overflow();
    int k;
    for (k = 0; k < MAX_CRYSTALS + 2; k++)
      send_crystal((k < MAX_CRYSTALS) ? FX_ONE : 32'sh03E8_0000, k == MAX_CRYSTALS + 1);
  endtask

  task automatic test_backpressure();
    int k;
    @(negedge clk);
    push <= 1'b0;
    hold_left = 400;
    for (k = 0; k < 30; k++) begin
      send_crystal($urandom, 1'b0);
      send_crystal($urandom, 1'b1);
    end
    settle();
  endtask

  task automatic test_random_phases();
    int                       p;
    int                       n;
    int                       len;
    int                       k;
    logic signed [DATA_W-1:0] v;
    logic [THR_W-1:0]         thr_pick;
    for (p = 0; p < 8; p++) begin
      case (p)
        0: thr_pick = '0;
        1: thr_pick = 31'h7FFF_FFFF;
        2: thr_pick = 31'd1;
        3: thr_pick = THR_W'($urandom_range(1, 3 << FRAC_W));
        4: thr_pick = '0;
        5: thr_pick = THR_W'($urandom);
        6: thr_pick = THR_W'($urandom_range(1 << (FRAC_W - 1), 2 << FRAC_W));
        default: thr_pick = THR_W'($urandom_range(1, 3 << FRAC_W));
      endcase
      write_threshold(thr_pick);
      n = 0;
      while (n < 160) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 40) : $urandom_range(1, 28);
        for (k = 0; k < len; k++) begin
          if (thr_pick == 0) begin
            case ($urandom_range(0, 15))
              0: v = 32'sh7FFF_FFFF;
              1: v = 32'sh8000_0000;
              default: v = $urandom;
            endcase
          end else begin
            case ($urandom_range(0, 9))
              0: v = {1'b1, 31'($urandom)};
              1: v = FX_TWO;
              2: v = FX_FIVE;
              3: v = FX_THREE;
              4: v = $urandom;
              5: v = '0;
              6, 7: v = $urandom_range(0, 2 * FX_ONE - 1);
              default: v = $urandom_range(2 * FX_ONE + 1, 6 * FX_ONE);
            endcase
          end
          send_crystal(v, k == len - 1);
          if (k < MAX_CRYSTALS)
            n++;
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_plain_extremes();
    test_quality_codes();
    test_threshold_change_mid_tower();
    test_crystal_overflow();
    test_backpressure();
    test_random_phases();
    settle();
    if (errors == 0 && tower_words_due.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
